>>> design/lmsl_pkg.sv
// shared constants and types for the longest monotone subsequence block
// no dependencies; imported by the top level and its checker
package lmsl_pkg;

    localparam int MAX_ELEMS = 1024;
    localparam int ADDR_W    = $clog2(MAX_ELEMS);
    localparam int CNT_W     = $clog2(MAX_ELEMS + 1);
    localparam int VAL_W     = 32;
    localparam int LEN_W     = 11;
    localparam int TOT_W     = 12;

    // one stored element with its two run lengths
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic        [LEN_W-1:0] inc;
        logic        [LEN_W-1:0] dec;
    } t_entry;

endpackage

>>> design/longest_monotone_subsequence_lengths.sv
// longest increasing / decreasing subsequence lengths over a beat stream
// depends on lmsl_pkg; one single-port-read, single-port-write element memory
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------------
//   in      | sink      | i_in_valid / o_in_stall | i_in_value, i_in_last
//   out     | source    | o_out_valid/i_out_stall | inc_length, dec_length, total, overflow
//
// an input beat is accepted, then gets one memory read per stored element plus one step to
// fold in the last read word, one write-back and one finish step; a beat that is dropped for
// lack of room goes from acceptance straight to its finish step
// the scan rate is set by the single read port of the element memory, one word a cycle
// reset is synchronous and active low; it clears the sequence counters and the result valid,
// the element memory itself is never cleared, only entries below the count are read
// a finished result sits in the output register and the next input beat may be taken while
// it waits; a second last beat waits in its finish cycle until that register is free
module longest_monotone_subsequence_lengths (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic signed [lmsl_pkg::VAL_W-1:0]  i_in_value,
    input  logic                               i_in_last,
    output logic                               o_in_stall,
    output logic                               o_out_valid,
    output logic        [lmsl_pkg::LEN_W-1:0]  o_out_inc_length,
    output logic        [lmsl_pkg::LEN_W-1:0]  o_out_dec_length,
    output logic        [lmsl_pkg::TOT_W-1:0]  o_out_total,
    output logic                               o_out_overflow,
    input  logic                               i_out_stall
);
    import lmsl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } t_state;

    t_state r_state;

    // element memory: value plus both run lengths per entry
    t_entry r_mem [MAX_ELEMS];
    t_entry r_q;

    // current beat and scan bookkeeping
    logic signed [VAL_W-1:0] r_key;
    logic                    r_last;
    logic [CNT_W-1:0]        r_j;
    logic                    r_rd_vld;
    logic [LEN_W-1:0]        r_inc;
    logic [LEN_W-1:0]        r_dec;

    // per-sequence state
    logic [CNT_W-1:0]        r_count;
    logic [LEN_W-1:0]        r_best_inc;
    logic [LEN_W-1:0]        r_best_dec;
    logic                    r_dropped;

    // result register
    logic                    r_out_valid;
    logic [LEN_W-1:0]        r_out_inc;
    logic [LEN_W-1:0]        r_out_dec;
    logic [TOT_W-1:0]        r_out_total;
    logic                    r_out_ovf;

    logic                    in_take;
    logic                    out_take;
    logic                    rd_en;
    logic                    wr_en;
    logic [LEN_W-1:0]        q_inc_p1;
    logic [LEN_W-1:0]        q_dec_p1;
    logic                    inc_hit;
    logic                    dec_hit;
    logic                    out_free;
    logic                    res_load;
    t_entry                  wr_data;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_take   = r_out_valid && !i_out_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    // a finished sequence moves into the result register
    assign res_load   = (r_state == S_DONE) && r_last && out_free;

    // one read per cycle over every stored earlier element
    assign rd_en = (r_state == S_SCAN) && (r_j < r_count);
    assign wr_en = (r_state == S_WRITE);

    assign wr_data.value = r_key;
    assign wr_data.inc   = r_inc;
    assign wr_data.dec   = r_dec;

    // fold the word read last cycle into the running lengths
    always_comb begin
        q_inc_p1 = r_q.inc + LEN_W'(1);
        q_dec_p1 = r_q.dec + LEN_W'(1);
        inc_hit  = r_rd_vld && (r_q.value < r_key) && (q_inc_p1 > r_inc);
        dec_hit  = r_rd_vld && (r_q.value > r_key) && (q_dec_p1 > r_dec);
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_q <= r_mem[r_j[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[ADDR_W-1:0]] <= wr_data;
        end
    end

    // sequencer with the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_j         <= '0;
            r_rd_vld    <= 1'b0;
            r_count     <= '0;
            r_best_inc  <= '0;
            r_best_dec  <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
            if (inc_hit) begin
                r_inc <= q_inc_p1;
            end
            if (dec_hit) begin
                r_dec <= q_dec_p1;
            end
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_key  <= i_in_value;
                        r_last <= i_in_last;
                        r_j    <= '0;
                        r_inc  <= LEN_W'(1);
                        r_dec  <= LEN_W'(1);
                        if (r_count == CNT_W'(MAX_ELEMS)) begin
                            // no room: drop the element, still honor last
                            r_dropped <= 1'b1;
                            r_state   <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (rd_en) begin
                        r_j <= r_j + CNT_W'(1);
                    end else begin
                        // the last read word is folded in this cycle
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_count <= r_count + CNT_W'(1);
                    if (r_inc > r_best_inc) begin
                        r_best_inc <= r_inc;
                    end
                    if (r_dec > r_best_dec) begin
                        r_best_dec <= r_dec;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out_inc   <= r_best_inc;
                        r_out_dec   <= r_best_dec;
                        r_out_total <= TOT_W'(r_best_inc) + TOT_W'(r_best_dec);
                        r_out_ovf   <= r_dropped;
                        r_count     <= '0;
                        r_best_inc  <= '0;
                        r_best_dec  <= '0;
                        r_dropped   <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_inc_length = r_out_inc;
    assign o_out_dec_length = r_out_dec;
    assign o_out_total      = r_out_total;
    assign o_out_overflow   = r_out_ovf;

endmodule

>>> design/lmsl_check.sv
// port-level checker for the longest monotone subsequence block
// depends on lmsl_pkg; bound to the top level at the end of this file
module lmsl_check (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic signed [lmsl_pkg::VAL_W-1:0]  i_in_value,
    input  logic                               i_in_last,
    input  logic                               o_in_stall,
    input  logic                               o_out_valid,
    input  logic        [lmsl_pkg::LEN_W-1:0]  o_out_inc_length,
    input  logic        [lmsl_pkg::LEN_W-1:0]  o_out_dec_length,
    input  logic        [lmsl_pkg::TOT_W-1:0]  o_out_total,
    input  logic                               o_out_overflow,
    input  logic                               i_out_stall
);
    import lmsl_pkg::*;

    // result holds while the sink stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_total)
            && $stable(o_out_inc_length) && $stable(o_out_dec_length)
            && $stable(o_out_overflow)))
        else $error("result changed while stalled");

    // total is the sum of the two lengths
    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_total ==
            (TOT_W'(o_out_inc_length) + TOT_W'(o_out_dec_length))))
        else $error("total does not match lengths");

    // every sequence holds at least one element, never more than capacity
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_inc_length != '0 && o_out_dec_length != '0
            && 32'(o_out_inc_length) <= MAX_ELEMS
            && 32'(o_out_dec_length) <= MAX_ELEMS))
        else $error("length out of range");

    // an accepted beat keeps the block busy for at least the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("beat taken without going busy");

endmodule

bind longest_monotone_subsequence_lengths lmsl_check u_lmsl_check (.*);
